@@ sv/svid_pkg.sv @@
// Shared types and constants for the semantic version identity validator.
// No dependencies; imported by every module of the block.
package svid_pkg;

  // Character and end-of-string item codes.
  localparam logic OpChar = 1'b0;
  localparam logic OpEnd  = 1'b1;

  // Grammar phase of the string being checked.
  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhCore  = 2'd1,
    PhPre   = 2'd2,
    PhBuild = 2'd3
  } phase_e;

  // Dev-form tracking: 0..3 chars of "dev-" matched, 4 full match, 5 mismatch.
  localparam logic [2:0] DevFull = 3'd4;
  localparam logic [2:0] DevMiss = 3'd5;
  localparam logic [3:0][7:0] DevText = {8'h2d, 8'h76, 8'h65, 8'h64}; // "dev-"

  localparam logic [5:0] ShaMin = 6'd7;
  localparam logic [5:0] ShaMax = 6'd40;

  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChZero  = 8'h30;

  localparam int unsigned CountW = 7;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic valid_res;
    logic is_dev_build;
    logic prefix_missing;
  } out_item_t;

  // Per-string scan state.
  typedef struct packed {
    phase_e              phase;
    logic [CountW-1:0]   char_count;
    logic [CountW-1:0]   part_length;
    logic                part_numeric;
    logic                part_leading_zero;
    logic [1:0]          core_index;
    logic [2:0]          dev_match;
    logic [5:0]          sha_length;
    logic                sha_bad;
    logic                failed;
    logic                saw_prefix_v;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    phase:             PhStart,
    char_count:        '0,
    part_length:       '0,
    part_numeric:      1'b1,
    part_leading_zero: 1'b0,
    core_index:        2'd0,
    dev_match:         3'd0,
    sha_length:        6'd0,
    sha_bad:           1'b0,
    failed:            1'b0,
    saw_prefix_v:      1'b0
  };

  // A list or core part is well formed: non-empty and, if zero_rule, no leading zero on a number.
  function automatic logic part_good(scan_state_t s, logic zero_rule);
    logic ok;
    ok = (s.part_length != '0);
    if (zero_rule && s.part_numeric && (s.part_length > 7'd1) && s.part_leading_zero) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

@@ sv/svid_step.sv @@
// Next scan state for one character item of the version string.
// Depends on svid_pkg.
module svid_step import svid_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 64
) (
  input  scan_state_t state_i,
  input  logic [7:0]  ch_i,
  output scan_state_t state_o
);

  localparam logic [CountW-1:0] LimitV   = CountW'(MAX_LENGTH);
  localparam logic [CountW-1:0] LimitNoV = CountW'(MAX_LENGTH - 1);

  logic is_digit, is_hex, is_item;

  always_comb begin
    is_digit = ch_i inside {[8'h30:8'h39]};
    is_hex   = is_digit || (ch_i inside {[8'h61:8'h66], [8'h41:8'h46]});
    is_item  = is_digit || (ch_i inside {[8'h41:8'h5a], [8'h61:8'h7a]}) || (ch_i == ChMinus);
  end

  scan_state_t s;
  logic        zero_rule;

  always_comb begin
    s = state_i;
    zero_rule = (state_i.phase == PhPre);

    // grammar
    if (s.phase == PhStart) begin
      s.phase = PhCore;
      if (ch_i == ChV) begin
        s.saw_prefix_v = 1'b1;
      end
    end
    if (state_i.char_count >= (s.saw_prefix_v ? LimitV : LimitNoV)) begin
      s.failed = 1'b1;
    end
    if (!s.failed && !(s.saw_prefix_v && state_i.char_count == '0)) begin
      if (s.phase == PhCore) begin
        if (is_digit) begin
          if (s.part_length == '0) s.part_leading_zero = (ch_i == ChZero);
          if (s.part_length != '1) s.part_length = s.part_length + 1'b1;
        end else if (ch_i == ChDot && s.core_index < 2'd2) begin
          if (!part_good(s, 1'b1)) s.failed = 1'b1;
          s.core_index        = s.core_index + 1'b1;
          s.part_length       = '0;
          s.part_numeric      = 1'b1;
          s.part_leading_zero = 1'b0;
        end else if ((ch_i == ChMinus || ch_i == ChPlus) && s.core_index == 2'd2) begin
          if (!part_good(s, 1'b1)) s.failed = 1'b1;
          s.phase             = (ch_i == ChMinus) ? PhPre : PhBuild;
          s.part_length       = '0;
          s.part_numeric      = 1'b1;
          s.part_leading_zero = 1'b0;
        end else begin
          s.failed = 1'b1;
        end
      end else begin
        if (is_item) begin
          if (s.part_length == '0) s.part_leading_zero = (ch_i == ChZero);
          if (!is_digit) s.part_numeric = 1'b0;
          if (s.part_length != '1) s.part_length = s.part_length + 1'b1;
        end else if (ch_i == ChDot || (ch_i == ChPlus && s.phase == PhPre)) begin
          if (!part_good(s, zero_rule)) s.failed = 1'b1;
          if (ch_i == ChPlus) s.phase = PhBuild;
          s.part_length       = '0;
          s.part_numeric      = 1'b1;
          s.part_leading_zero = 1'b0;
        end else begin
          s.failed = 1'b1;
        end
      end
    end

    // dev-form tracking
    if (state_i.dev_match < DevFull) begin
      if (ch_i == DevText[state_i.dev_match[1:0]]) begin
        s.dev_match = state_i.dev_match + 1'b1;
      end else begin
        s.dev_match = DevMiss;
      end
    end else if (state_i.dev_match == DevFull) begin
      if (!is_hex) s.sha_bad = 1'b1;
      if (state_i.sha_length <= ShaMax) s.sha_length = state_i.sha_length + 1'b1;
    end

    if (state_i.char_count != '1) begin
      s.char_count = state_i.char_count + 1'b1;
    end

    state_o = s;
  end

endmodule

@@ sv/svid_verdict.sv @@
// Verdict for an end item from the accumulated scan state and the mode bit.
// Depends on svid_pkg.
module svid_verdict import svid_pkg::*; (
  input  scan_state_t state_i,
  input  logic        identity_mode_i,
  output out_item_t   result_o
);

  logic grammar_ok, valid, dev;

  always_comb begin
    grammar_ok = !state_i.failed && (state_i.phase != PhStart) &&
                 !(state_i.phase == PhCore && state_i.char_count == 7'd1 &&
                   state_i.saw_prefix_v) &&
                 part_good(state_i, state_i.phase != PhBuild) &&
                 (state_i.phase != PhCore || state_i.core_index == 2'd2);
    dev = 1'b0;
    if (identity_mode_i && state_i.dev_match == DevFull) begin
      valid = !state_i.sha_bad && (state_i.sha_length >= ShaMin) &&
              (state_i.sha_length <= ShaMax);
      dev   = valid;
    end else if (identity_mode_i) begin
      valid = grammar_ok && state_i.saw_prefix_v;
    end else begin
      valid = grammar_ok;
    end
    result_o.valid_res      = valid;
    result_o.is_dev_build   = dev;
    result_o.prefix_missing = valid && !dev && !state_i.saw_prefix_v;
  end

endmodule

@@ sv/semver_identity_validator_core.sv @@
// Top level of the semantic version identity validator.
// Depends on svid_pkg, svid_step and svid_verdict.
//   The input channel (in_valid_i / in_ready_o / in_data_i) carries one item
//   per handshake: a character (op = char) or an end-of-string marker.
//   Characters update the scan state in the cycle they are accepted and give
//   no result. An end item produces exactly one verdict item on the output
//   channel (out_valid_o / out_ready_i / out_data_o), registered, so it is
//   visible the cycle after the end item is accepted, and the scan state
//   returns to its start value for the next string.
//   Throughput: one item per cycle unless a verdict stalls; the scan state
//   register is the only loop and its update is a single level of character
//   classify-and-update logic. A stalled receiver only holds off the input
//   while a verdict is waiting and not being taken in the same cycle; the
//   output register then keeps the verdict stable.
//   The cfg channel writes identity_mode (always ready); write it only while
//   no string is in flight. identity_mode is sampled at the end item.
//   Reset (rst_ni low, asynchronous) clears the scan state, empties the
//   output register and sets identity_mode to plain semver checking.
//   Strings longer than MAX_LENGTH - 1 characters (MAX_LENGTH with a leading
//   'v') fail; the dev-hash form is held to a 7..40 hex digit hash instead.
module semver_identity_validator_core import svid_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  scan_state_t state_q, state_d, state_char;
  out_item_t   verdict, out_data_q;
  logic        out_valid_q;
  logic        mode_q;
  logic        in_fire;

  // Accept whenever the output slot is free or being drained this cycle.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  svid_step #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_step (
    .state_i(state_q),
    .ch_i   (in_data_i.ch),
    .state_o(state_char)
  );

  svid_verdict u_verdict (
    .state_i        (state_q),
    .identity_mode_i(mode_q),
    .result_o       (verdict)
  );

  // End item: verdict out, scan state back to start of string.
  always_comb begin
    state_d = state_q;
    if (in_fire) begin
      state_d = (in_data_i.op == OpEnd) ? ScanReset : state_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ScanReset;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (in_fire && in_data_i.op == OpEnd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.op == OpEnd) begin
      out_data_q <= verdict;
    end
  end

  // A dev-build verdict is always an accepting one and only in identity mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_dev_build |-> out_data_o.valid_res)
    else $error("dev build flagged on rejected string");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.prefix_missing |->
      out_data_o.valid_res && !out_data_o.is_dev_build)
    else $error("prefix_missing on rejected or dev string");

  // After an end item the scan starts over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.op == OpEnd |=>
      state_q.char_count == '0 && state_q.phase == PhStart)
    else $error("scan state not cleared after end item");

  // A verdict waiting on a stalled receiver blocks new items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while verdict stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.dev_match <= DevMiss && state_q.sha_length <= (ShaMax + 6'd1))
    else $error("dev tracking out of range");

endmodule
